// ----- sv/csb_pkg.sv -----
// Shared types and codes for the counting semaphore bank.
package csb_pkg;

  // Operation carried in the kind field.
  localparam logic KIND_P = 1'b0;
  localparam logic KIND_V = 1'b1;

  // Result status codes.
  typedef logic [2:0] status_t;
  localparam status_t ST_GRANTED  = 3'd0;
  localparam status_t ST_QUEUED   = 3'd1;
  localparam status_t ST_RELEASED = 3'd2;
  localparam status_t ST_HANDED   = 3'd3;
  localparam status_t ST_BAD_SEM  = 3'd4;
  localparam status_t ST_BAD_PROC = 3'd5;
  localparam status_t ST_FULL     = 3'd6;

  // Request class decided by the front end.
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_OK       = 2'd0;
  localparam cls_t CLS_BAD_SEM  = 2'd1;
  localparam cls_t CLS_BAD_PROC = 2'd2;

  // Count limits and reset value.
  typedef logic signed [5:0] count_t;
  localparam count_t COUNT_MAX = 6'sd15;
  localparam count_t COUNT_RST = 6'sd1;

  // Classified request passed from the front end to the back end.
  typedef struct packed {
    logic       kind;
    logic [3:0] sem_idx;
    logic [7:0] pid;
    cls_t       cls;
  } cmd_t;

  // One result word.
  typedef struct packed {
    count_t     new_count;
    logic [7:0] owner_pid;
    logic       owner_valid;
    status_t    status;
  } res_t;

endpackage

// ----- sv/csb_front.sv -----
// Front end: accepts request words, classifies them and buffers them in a two-word queue.
module csb_front import csb_pkg::*; #(
  parameter int SEMAPHORES = 8,
  parameter int PROCESSES  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sem_index[3:0], requester_pid[11:4], zero pad
  input  logic [0:0]  in_tuser,   // kind[0]
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  localparam int QDEPTH = 2;
  localparam logic [1:0] FILL_FULL = 2'(QDEPTH);

  cmd_t       slot_r [QDEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  cmd_t       cmd_in;
  logic       bad_sem;
  logic       bad_pid;
  logic       push;

  // Range checks on the incoming word.
  assign bad_sem = {1'b0, in_tdata[3:0]} >= 5'(SEMAPHORES);
  assign bad_pid = {1'b0, in_tdata[11:4]} >= 9'(PROCESSES);

  // Classify the request.
  always_comb begin
    cmd_in.kind    = in_tuser[0];
    cmd_in.sem_idx = in_tdata[3:0];
    cmd_in.pid     = in_tdata[11:4];
    priority if (bad_sem) begin
      cmd_in.cls = CLS_BAD_SEM;
    end else if (in_tuser[0] == KIND_P && bad_pid) begin
      cmd_in.cls = CLS_BAD_PROC;
    end else begin
      cmd_in.cls = CLS_OK;
    end
  end

  assign in_tready = (fill_r != FILL_FULL);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign q_cmd     = slot_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, q_pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ----- sv/csb_back.sv -----
// Back end: per-semaphore state, wait-queue memory and the result register.
module csb_back import csb_pkg::*; #(
  parameter int SEMAPHORES  = 8,
  parameter int QUEUE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wen,
  input  logic [3:0] cfg_wdata,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       res_valid,
  output res_t       res_data,
  input  logic       res_ready
);

  localparam int SEM_IW    = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int LEN_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = SEMAPHORES * QUEUE_DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [SEM_IW-1:0] s,
                                                 input logic [PTR_W-1:0] p);
    return MEM_AW'(s * QUEUE_DEPTH) + MEM_AW'(p);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Per-semaphore state.
  count_t           count_r    [SEMAPHORES];
  logic [7:0]       owner_id_r [SEMAPHORES];
  logic             owner_vld_r[SEMAPHORES];
  logic [PTR_W-1:0] head_r     [SEMAPHORES];
  logic [PTR_W-1:0] tail_r     [SEMAPHORES];
  logic [LEN_W-1:0] len_r      [SEMAPHORES];

  logic [7:0]        wait_mem [MEM_DEPTH];
  logic [7:0]        mem_rdata_r;
  logic              state_r;
  cmd_t              cmd_r;
  logic              out_valid_r;
  res_t              out_data_r;

  logic [SEM_IW-1:0] pop_idx;
  logic [PTR_W-1:0]  pop_head;
  logic [SEM_IW-1:0] idx;
  logic              fire;
  logic              upd;
  logic              mem_we;
  count_t            cur_cnt;
  count_t            inc_cnt;
  count_t            new_cnt;
  logic [7:0]        new_own;
  logic              new_vld;
  logic [PTR_W-1:0]  new_head;
  logic [PTR_W-1:0]  new_tail;
  logic [LEN_W-1:0]  new_len;
  status_t           status;
  res_t              res_nxt;

  // A word is taken from the queue only when the back end is idle.
  assign q_pop    = q_valid && (state_r == ST_IDLE);
  assign pop_idx  = q_cmd.sem_idx[SEM_IW-1:0];
  assign pop_head = (q_cmd.cls == CLS_BAD_SEM) ? '0 : head_r[pop_idx];

  assign idx     = cmd_r.sem_idx[SEM_IW-1:0];
  assign fire    = (state_r == ST_EXEC) && (!out_valid_r || res_ready);
  assign cur_cnt = count_r[idx];
  assign inc_cnt = (cur_cnt < COUNT_MAX) ? cur_cnt + 6'sd1 : cur_cnt;

  // Work out the step for the held request.
  always_comb begin
    upd      = 1'b0;
    mem_we   = 1'b0;
    new_cnt  = cur_cnt;
    new_own  = owner_id_r[idx];
    new_vld  = owner_vld_r[idx];
    new_head = head_r[idx];
    new_tail = tail_r[idx];
    new_len  = len_r[idx];
    status   = ST_GRANTED;
    priority if (cmd_r.cls == CLS_BAD_SEM) begin
      status = ST_BAD_SEM;
    end else if (cmd_r.cls == CLS_BAD_PROC) begin
      status = ST_BAD_PROC;
    end else if (cmd_r.kind == KIND_P) begin
      priority if (cur_cnt > 6'sd0) begin
        upd     = 1'b1;
        new_cnt = cur_cnt - 6'sd1;
        new_own = cmd_r.pid;
        new_vld = 1'b1;
        status  = ST_GRANTED;
      end else if (len_r[idx] == LEN_W'(QUEUE_DEPTH)) begin
        status = ST_FULL;
      end else begin
        upd      = 1'b1;
        mem_we   = 1'b1;
        new_tail = ptr_inc(tail_r[idx]);
        new_len  = len_r[idx] + LEN_W'(1);
        new_cnt  = cur_cnt - 6'sd1;
        status   = ST_QUEUED;
      end
    end else begin
      upd     = 1'b1;
      new_cnt = inc_cnt;
      if (len_r[idx] != '0) begin
        new_own  = mem_rdata_r;
        new_vld  = 1'b1;
        new_head = ptr_inc(head_r[idx]);
        new_len  = len_r[idx] - LEN_W'(1);
        status   = ST_HANDED;
      end else begin
        status = ST_RELEASED;
      end
    end
    res_nxt.status = status;
    if (cmd_r.cls == CLS_BAD_SEM) begin
      res_nxt.owner_valid = 1'b0;
      res_nxt.owner_pid   = 8'd0;
      res_nxt.new_count   = 6'sd0;
    end else begin
      res_nxt.owner_valid = new_vld;
      res_nxt.owner_pid   = new_own;
      res_nxt.new_count   = new_cnt;
    end
  end

  // Wait-queue memory: head read on pop, tail write on enqueue.
  always_ff @(posedge clk) begin
    if (fire && mem_we) begin
      wait_mem[mem_addr(idx, tail_r[idx])] <= cmd_r.pid;
    end
    if (q_pop) begin
      mem_rdata_r <= wait_mem[mem_addr(pop_idx, pop_head)];
    end
  end

  // Held request.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (q_pop) begin
      state_r <= ST_EXEC;
    end else if (fire) begin
      state_r <= ST_IDLE;
    end
  end

  // Semaphore state update, reinitialized by reset or a configuration write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEMAPHORES; i++) begin
        count_r[i]     <= COUNT_RST;
        owner_id_r[i]  <= 8'd0;
        owner_vld_r[i] <= 1'b0;
        head_r[i]      <= '0;
        tail_r[i]      <= '0;
        len_r[i]       <= '0;
      end
    end else if (cfg_wen) begin
      for (int i = 0; i < SEMAPHORES; i++) begin
        count_r[i]     <= $signed({2'b00, cfg_wdata});
        owner_id_r[i]  <= 8'd0;
        owner_vld_r[i] <= 1'b0;
        head_r[i]      <= '0;
        tail_r[i]      <= '0;
        len_r[i]       <= '0;
      end
    end else if (fire && upd) begin
      count_r[idx]     <= new_cnt;
      owner_id_r[idx]  <= new_own;
      owner_vld_r[idx] <= new_vld;
      head_r[idx]      <= new_head;
      tail_r[idx]      <= new_tail;
      len_r[idx]       <= new_len;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (res_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign res_valid = out_valid_r;
  assign res_data  = out_data_r;

endmodule

// ----- sv/counting_semaphore_bank_top.sv -----
// Top level of the counting semaphore bank.
//
// A bank of SEMAPHORES counting semaphores, each with a FIFO wait queue of up to
// QUEUE_DEPTH process ids. Each request word (P or V) yields exactly one result word
// with a status, the semaphore's owner and its count after the step. The back end
// handles one request at a time: taking a word reads the head entry of the
// wait-queue memory, then the exec step updates the semaphore and loads the result
// register. A two-word queue in front lets requests arrive while a
// result waits to be taken. A write to cfg_wdata sets every count to the written
// value and empties every queue and owner; write it only while the bank is idle.
module counting_semaphore_bank_top import csb_pkg::*; #(
  parameter int SEMAPHORES  = 8,
  parameter int PROCESSES   = 32,
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sem_index[3:0], requester_pid[11:4], zero pad
  input  logic [0:0]  in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // status[2:0], owner_valid[3], owner_pid[11:4],
                                  // new_count[17:12], zero pad
);

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;
  res_t res_data;

  // Request intake and classification.
  csb_front #(
    .SEMAPHORES(SEMAPHORES),
    .PROCESSES (PROCESSES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // Semaphore state and result generation.
  csb_back #(
    .SEMAPHORES (SEMAPHORES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .res_valid(out_tvalid),
    .res_data (res_data),
    .res_ready(out_tready)
  );

  // Pack the result word.
  assign out_tdata = {6'd0, res_data.new_count, res_data.owner_pid,
                      res_data.owner_valid, res_data.status};

endmodule

// ----- sim/tb_counting_semaphore_bank_top.sv -----
// Self-checking testbench for the counting semaphore bank top level.
module tb_counting_semaphore_bank_top;
  import csb_pkg::*;

  localparam int NUM_SEMS    = 8;
  localparam int NUM_PROCS   = 32;
  localparam int QDEPTH      = 32;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wen;
  logic [3:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // sem_index[3:0], requester_pid[11:4], zero pad
  logic [0:0]  in_tuser;   // kind[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // status[2:0], owner_valid[3], owner_pid[11:4],
                           // new_count[17:12], zero pad

  counting_semaphore_bank_top #(
    .SEMAPHORES (NUM_SEMS),
    .PROCESSES  (NUM_PROCS),
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // One row of the directed plan: either a register write or a request.
  typedef struct {
    bit         is_cfg;
    logic [3:0] cfg_val;
    logic       kind;
    logic [3:0] sem;
    logic [7:0] pid;
    bit         typed;
    res_t       want;
  } plan_row_t;

  // Shadow copy of the semaphore bank.
  int         sem_cnt     [NUM_SEMS];
  logic [7:0] owner_pid_q [NUM_SEMS];
  bit         owner_ok    [NUM_SEMS];
  logic [7:0] wait_pid    [NUM_SEMS][QDEPTH];
  int         wait_head   [NUM_SEMS];
  int         wait_tail   [NUM_SEMS];
  int         wait_len    [NUM_SEMS];

  res_t       expected_results[$];
  plan_row_t  plan[$];
  int         error_count;
  int         cycle_count;
  int         rx_hold;
  bit         no_gaps;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reloads every count and empties every queue and owner record.
  function automatic void load_initial_count(input logic [3:0] v);
    for (int i = 0; i < NUM_SEMS; i++) begin
      sem_cnt[i]     = int'(v);
      owner_pid_q[i] = '0;
      owner_ok[i]    = 1'b0;
      wait_head[i]   = 0;
      wait_tail[i]   = 0;
      wait_len[i]    = 0;
    end
  endfunction

  // Applies one P or V request to the shadow bank and returns its result word.
  function automatic res_t apply_request(input logic k, input logic [3:0] s,
                                         input logic [7:0] p);
    res_t    r;
    status_t st;
    r = '0;
    if (s >= NUM_SEMS) begin
      r.status = ST_BAD_SEM;
    end else begin
      if (k == KIND_P) begin
        if (p >= NUM_PROCS) begin
          st = ST_BAD_PROC;
        end else if (sem_cnt[s] >= 1) begin
          sem_cnt[s]--;
          owner_pid_q[s] = p;
          owner_ok[s]    = 1'b1;
          st = ST_GRANTED;
        end else if (wait_len[s] >= QDEPTH) begin
          st = ST_FULL;
        end else begin
          wait_pid[s][wait_tail[s]] = p;
          wait_tail[s] = (wait_tail[s] + 1) % QDEPTH;
          wait_len[s]++;
          sem_cnt[s]--;
          st = ST_QUEUED;
        end
      end else if (wait_len[s] > 0) begin
        // The oldest waiter takes over the semaphore.
        owner_pid_q[s] = wait_pid[s][wait_head[s]];
        owner_ok[s]    = 1'b1;
        wait_head[s]   = (wait_head[s] + 1) % QDEPTH;
        wait_len[s]--;
        if (sem_cnt[s] < int'(COUNT_MAX)) sem_cnt[s]++;
        st = ST_HANDED;
      end else begin
        if (sem_cnt[s] < int'(COUNT_MAX)) sem_cnt[s]++;
        st = ST_RELEASED;
      end
      r.status      = st;
      r.owner_valid = owner_ok[s];
      r.owner_pid   = owner_pid_q[s];
      r.new_count   = count_t'(sem_cnt[s]);
    end
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic plan_row_t req_row(input logic k, input logic [3:0] s,
                                        input logic [7:0] p, input bit typed,
                                        input status_t st, input logic ov,
                                        input logic [7:0] op, input int cnt);
    plan_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_val = '0;
    row.kind    = k;
    row.sem     = s;
    row.pid     = p;
    row.typed   = typed;
    row.want.status      = st;
    row.want.owner_valid = ov;
    row.want.owner_pid   = op;
    row.want.new_count   = count_t'(cnt);
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [3:0] v);
    plan_row_t row;
    row = req_row(KIND_P, '0, '0, 1'b0, ST_GRANTED, 1'b0, '0, 0);
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    return row;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Compares one received word with the oldest outstanding expectation.
  task automatic check_result(input logic [23:0] word);
    res_t got;
    res_t want;
    got = res_t'(word[17:0]);
    if (expected_results.size() == 0) begin
      report_mismatch("word with nothing outstanding, status", int'(got.status), -1);
    end else begin
      want = expected_results.pop_front();
      if (got.status != want.status)
        report_mismatch("status", int'(got.status), int'(want.status));
      if (got.owner_valid != want.owner_valid)
        report_mismatch("owner_valid", int'(got.owner_valid), int'(want.owner_valid));
      if (got.owner_pid != want.owner_pid)
        report_mismatch("owner_pid", int'(got.owner_pid), int'(want.owner_pid));
      if (got.new_count != want.new_count)
        report_mismatch("new_count", int'(got.new_count), int'(want.new_count));
    end
  endtask

  // Optional idle cycles on the request side after a word was taken.
  task automatic idle_sender();
    int n;
    n = no_gaps ? 0 : pick_gap();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Presents one request word and holds it until the bank takes it.
  task automatic send_request(input logic k, input logic [3:0] s, input logic [7:0] p,
                              input bit typed, input res_t typed_res);
    res_t pred;
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {4'b0000, p, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = apply_request(k, s, p);
    expected_results.push_back(typed ? typed_res : pred);
    idle_sender();
  endtask

  // Holds the requests back until every outstanding word has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Writes the initial count while the bank is idle.
  task automatic write_initial_count(input logic [3:0] v);
    drain();
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    load_initial_count(v);
  endtask

  // Random requests: p_weight percent P, semaphores below sem_span, some bad words.
  task automatic run_random_phase(input int items, input int p_weight, input int sem_span,
                                  input bit calm);
    logic       k;
    logic [3:0] s;
    logic [7:0] p;
    int         r;
    no_gaps = calm;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        k = 1'($urandom_range(1));
        s = 4'($urandom_range(15, NUM_SEMS));
        p = 8'($urandom_range(255));
      end else begin
        k = ($urandom_range(99) < p_weight) ? KIND_P : KIND_V;
        s = 4'($urandom_range(sem_span - 1));
        if (k == KIND_V)
          p = 8'($urandom_range(255));
        else if (r < 7)
          p = 8'($urandom_range(255, NUM_PROCS));
        else
          p = 8'($urandom_range(NUM_PROCS - 1));
      end
      if ($urandom_range(299) == 0) drain();
      send_request(k, s, p, 1'b0, '0);
    end
    no_gaps = 1'b0;
  endtask

  // Result side: check accepted words and toggle out_tready at random.
  always @(posedge clk) begin : rx_side
    int gap;
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
      end else if (no_gaps) begin
        out_tready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_tready <= 1'b1;
          rx_hold    <= $urandom_range(8);
        end else begin
          out_tready <= 1'b0;
          rx_hold    <= gap;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[counting_semaphore_bank_top] ERROR");
      $finish;
    end
  end

  // Stimulus and end of test.
  initial begin
    rst_n       = 1'b0;
    cfg_wen     = 1'b0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    error_count = 0;
    cycle_count = 0;
    rx_hold     = 0;
    no_gaps     = 1'b0;
    load_initial_count(COUNT_RST[3:0]);

    // Directed plan; counts start at one after reset.
    plan.push_back(req_row(KIND_P, 4'd0,  8'd5,   1, ST_GRANTED,  1, 8'd5,  0));
    plan.push_back(req_row(KIND_P, 4'd0,  8'd31,  1, ST_QUEUED,   1, 8'd5,  -1));
    plan.push_back(req_row(KIND_P, 4'd0,  8'd0,   1, ST_QUEUED,   1, 8'd5,  -2));
    plan.push_back(req_row(KIND_V, 4'd0,  8'd255, 1, ST_HANDED,   1, 8'd31, -1));
    plan.push_back(req_row(KIND_V, 4'd0,  8'd0,   1, ST_HANDED,   1, 8'd0,  0));
    plan.push_back(req_row(KIND_V, 4'd0,  8'd0,   1, ST_RELEASED, 1, 8'd0,  1));
    plan.push_back(req_row(KIND_V, 4'd7,  8'd0,   1, ST_RELEASED, 0, 8'd0,  2));
    plan.push_back(req_row(KIND_P, 4'd15, 8'd255, 1, ST_BAD_SEM,  0, 8'd0,  0));
    plan.push_back(req_row(KIND_V, 4'd8,  8'd0,   1, ST_BAD_SEM,  0, 8'd0,  0));
    plan.push_back(req_row(KIND_P, 4'd7,  8'd32,  1, ST_BAD_PROC, 0, 8'd0,  2));
    plan.push_back(req_row(KIND_P, 4'd3,  8'd255, 1, ST_BAD_PROC, 0, 8'd0,  1));
    plan.push_back(req_row(KIND_P, 4'd7,  8'd31,  1, ST_GRANTED,  1, 8'd31, 1));
    plan.push_back(req_row(KIND_P, 4'd7,  8'd17,  1, ST_GRANTED,  1, 8'd17, 0));
    plan.push_back(req_row(KIND_P, 4'd7,  8'd10,  0, ST_GRANTED,  0, 8'd0,  0));
    // Count starts at the ceiling, so a release saturates.
    plan.push_back(cfg_row(4'd15));
    plan.push_back(req_row(KIND_V, 4'd2,  8'd0,   1, ST_RELEASED, 0, 8'd0,  15));
    plan.push_back(req_row(KIND_P, 4'd2,  8'd1,   1, ST_GRANTED,  1, 8'd1,  14));
    plan.push_back(req_row(KIND_P, 4'd5,  8'd21,  0, ST_GRANTED,  0, 8'd0,  0));
    // Count starts at zero, so the first P waits.
    plan.push_back(cfg_row(4'd0));
    plan.push_back(req_row(KIND_P, 4'd6,  8'd3,   1, ST_QUEUED,   0, 8'd0,  -1));
    plan.push_back(req_row(KIND_V, 4'd6,  8'd0,   1, ST_HANDED,   1, 8'd3,  0));
    plan.push_back(req_row(KIND_V, 4'd6,  8'd0,   1, ST_RELEASED, 1, 8'd3,  1));
    plan.push_back(req_row(KIND_P, 4'd1,  8'd128, 1, ST_BAD_PROC, 0, 8'd0,  0));
    plan.push_back(req_row(KIND_V, 4'd7,  8'd0,   0, ST_GRANTED,  0, 8'd0,  0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_initial_count(plan[i].cfg_val);
      else
        send_request(plan[i].kind, plan[i].sem, plan[i].pid, plan[i].typed, plan[i].want);
    end

    // Empty start and few semaphores: queues fill up to full.
    write_initial_count(4'd0);
    run_random_phase(400, 75, 2, 1'b0);
    // Full start and release-heavy traffic: counts saturate at the ceiling.
    write_initial_count(4'd15);
    run_random_phase(400, 35, NUM_SEMS, 1'b0);
    // Random start, back-to-back traffic with no inserted gaps.
    write_initial_count(4'($urandom_range(15)));
    run_random_phase(400, 55, NUM_SEMS, 1'b1);
    // Back to the reset value, balanced traffic.
    write_initial_count(COUNT_RST[3:0]);
    run_random_phase(400, 50, 4, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("words never received", 0, expected_results.size());
    if (error_count == 0)
      $display("[counting_semaphore_bank_top] OK");
    else
      $display("[counting_semaphore_bank_top] ERROR");
    $finish;
  end

endmodule
